// ===== rtl/core/tgarle_pkg.sv =====
// Shared types and constants for the TGA RLE pixel decoder.
// Used by every module of the block; has no dependencies of its own.
`default_nettype none

package tgarle_pkg;

	localparam int unsigned TYPE_HDR_LEN = 12;
	localparam int unsigned IMG_HDR_LEN  = 6;

	localparam logic [7:0] TYPE_CODE_UNC = 8'd2;
	localparam logic [7:0] TYPE_CODE_RLE = 8'd10;
	localparam logic [3:0] TYPE_CODE_POS = 4'd2;
	localparam logic [7:0] DEPTH_24      = 8'd24;
	localparam logic [7:0] DEPTH_32      = 8'd32;
	localparam logic [7:0] RUN_BIAS      = 8'd127;
	localparam logic [7:0] ALPHA_OPAQUE  = 8'hFF;

	typedef enum logic [1:0] {
		ST_PIXEL    = 2'd0,
		ST_BAD_TYPE = 2'd1,
		ST_BAD_SIZE = 2'd2,
		ST_OVERRUN  = 2'd3
	} status_t;

	// One result as the parser leaves it: stored bytes still in file order.
	typedef struct packed {
		logic [7:0]  px_b0;
		logic [7:0]  px_b1;
		logic [7:0]  px_b2;
		logic [7:0]  px_b3;
		logic [7:0]  rep;
		logic        four;
		logic [15:0] width;
		logic [15:0] height;
		logic        last;
		status_t     status;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_flags_t;

	// Expected byte of the 12-byte type header; only the image type byte is nonzero.
	function automatic logic [7:0] type_byte(input logic rle, input logic [3:0] idx);
		logic [7:0] code;
		code = rle ? TYPE_CODE_RLE : TYPE_CODE_UNC;
		return (idx == TYPE_CODE_POS) ? code : 8'd0;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/tgarle_front.sv =====
// Byte parser: type header, image header, raw and RLE packet tracking.
// Pushes one entry per result into the queue. Depends on tgarle_pkg.
`default_nettype none

module tgarle_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire logic [7:0]          data_byte,
	input  wire logic                start_of_file,
	input  wire tgarle_pkg::q_flags_t q_flags,
	output logic                     push,
	output tgarle_pkg::entry_t       push_data
);

	typedef enum logic [2:0] {
		PH_TYPE    = 3'd0,
		PH_IMG     = 3'd1,
		PH_RAWBODY = 3'd2,
		PH_PKTHDR  = 3'd3,
		PH_PKTPIX  = 3'd4,
		PH_IDLE    = 3'd5
	} phase_t;

	phase_t      phase_q, n_phase, cur_phase;
	logic [3:0]  hdr_q, n_hdr, cur_hdr;
	logic [1:0]  match_q, n_match, cur_match;
	logic        comp_q, n_comp, cur_comp;
	logic [15:0] width_q, n_width, cur_width;
	logic [15:0] height_q, n_height, cur_height;
	logic        four_q, n_four, cur_four;
	logic [31:0] pix_left_q, n_pix_left, cur_pix_left;
	logic [7:0]  pkt_left_q, n_pkt_left, cur_pkt_left;
	logic        run_q, n_run, cur_run;
	logic [1:0]  pbi_q, n_pbi, cur_pbi;
	logic [23:0] pb_q, n_pb, cur_pb;

	logic        accept;
	logic        emit;
	logic [31:0] area;

	assign in_stall = q_flags.full;
	assign accept   = in_valid && !in_stall;
	assign push     = accept && emit;
	assign area     = {16'd0, width_q} * {16'd0, height_q};

	always_comb begin
		logic [3:0]  ti;
		logic [1:0]  m;
		logic [1:0]  fin;
		logic        g_done;
		logic [1:0]  g_pbi;
		logic [23:0] g_pb;
		logic [7:0]  pl;
		logic [7:0]  rep;
		logic [7:0]  depth;
		logic [31:0] dec;

		// start_of_file restarts parsing and this byte is type byte 0
		cur_phase    = start_of_file ? PH_TYPE : phase_q;
		cur_hdr      = start_of_file ? 4'd0 : hdr_q;
		cur_match    = start_of_file ? 2'b11 : match_q;
		cur_comp     = start_of_file ? 1'b0 : comp_q;
		cur_width    = start_of_file ? 16'd0 : width_q;
		cur_height   = start_of_file ? 16'd0 : height_q;
		cur_four     = start_of_file ? 1'b0 : four_q;
		cur_pix_left = start_of_file ? 32'd0 : pix_left_q;
		cur_pkt_left = start_of_file ? 8'd0 : pkt_left_q;
		cur_run      = start_of_file ? 1'b0 : run_q;
		cur_pbi      = start_of_file ? 2'd0 : pbi_q;
		cur_pb       = start_of_file ? 24'd0 : pb_q;

		n_phase    = cur_phase;
		n_hdr      = cur_hdr;
		n_match    = cur_match;
		n_comp     = cur_comp;
		n_width    = cur_width;
		n_height   = cur_height;
		n_four     = cur_four;
		n_pix_left = cur_pix_left;
		n_pkt_left = cur_pkt_left;
		n_run      = cur_run;
		n_pbi      = cur_pbi;
		n_pb       = cur_pb;

		emit      = 1'b0;
		push_data = '0;
		push_data.status = tgarle_pkg::ST_PIXEL;

		// pixel byte gathering, shared by raw body and packet pixels
		fin    = cur_four ? 2'd3 : 2'd2;
		g_done = (cur_pbi == fin);
		g_pb   = cur_pb;
		g_pbi  = cur_pbi + 2'd1;
		unique case (cur_pbi)
			2'd0: g_pb[7:0]   = data_byte;
			2'd1: g_pb[15:8]  = data_byte;
			2'd2: g_pb[23:16] = data_byte;
			default: ;
		endcase
		if (g_done) begin
			g_pb  = '0;
			g_pbi = 2'd0;
		end

		ti    = (cur_hdr < 4'(tgarle_pkg::TYPE_HDR_LEN)) ? cur_hdr
			: 4'(tgarle_pkg::TYPE_HDR_LEN - 1);
		m     = cur_match;
		pl    = data_byte[7] ? (data_byte - tgarle_pkg::RUN_BIAS) : (data_byte + 8'd1);
		rep   = cur_run ? cur_pkt_left : 8'd1;
		depth = cur_pb[7:0];
		dec   = cur_pix_left - {24'd0, (cur_phase == PH_PKTPIX) ? rep : 8'd1};

		unique case (cur_phase)
			PH_TYPE: begin
				if (data_byte != tgarle_pkg::type_byte(1'b0, ti))
					m[0] = 1'b0;
				if (data_byte != tgarle_pkg::type_byte(1'b1, ti))
					m[1] = 1'b0;
				n_match = m;
				if (ti < 4'(tgarle_pkg::TYPE_HDR_LEN - 1)) begin
					n_hdr = ti + 4'd1;
				end else begin
					n_hdr = 4'd0;
					if (m[0]) begin
						n_comp  = 1'b0;
						n_phase = PH_IMG;
					end else if (m[1]) begin
						n_comp  = 1'b1;
						n_phase = PH_IMG;
					end else begin
						emit             = 1'b1;
						push_data.last   = 1'b1;
						push_data.status = tgarle_pkg::ST_BAD_TYPE;
						n_phase          = PH_IDLE;
					end
				end
			end
			PH_IMG: begin
				unique case (cur_hdr)
					4'd0: n_width[7:0]   = data_byte;
					4'd1: n_width[15:8]  = data_byte;
					4'd2: n_height[7:0]  = data_byte;
					4'd3: n_height[15:8] = data_byte;
					4'd4: begin
						n_four = (data_byte == tgarle_pkg::DEPTH_32);
						n_pb   = {16'd0, data_byte};
					end
					default: ;
				endcase
				if (cur_hdr < 4'(tgarle_pkg::IMG_HDR_LEN - 1)) begin
					n_hdr = cur_hdr + 4'd1;
				end else begin
					n_hdr = 4'd0;
					n_pb  = '0;
					if (cur_width == 16'd0 || cur_height == 16'd0 ||
						(depth != tgarle_pkg::DEPTH_24 && depth != tgarle_pkg::DEPTH_32)) begin
						emit             = 1'b1;
						push_data.last   = 1'b1;
						push_data.status = tgarle_pkg::ST_BAD_SIZE;
						n_phase          = PH_IDLE;
					end else begin
						n_pix_left = area;
						n_phase    = cur_comp ? PH_PKTHDR : PH_RAWBODY;
					end
				end
			end
			PH_RAWBODY: begin
				n_pb  = g_pb;
				n_pbi = g_pbi;
				if (g_done) begin
					n_pix_left       = dec;
					emit             = 1'b1;
					push_data.px_b0  = cur_pb[7:0];
					push_data.px_b1  = cur_pb[15:8];
					push_data.px_b2  = cur_pb[23:16];
					push_data.px_b3  = data_byte;
					push_data.rep    = 8'd1;
					push_data.last   = (dec == 32'd0);
					if (dec == 32'd0)
						n_phase = PH_IDLE;
				end
			end
			PH_PKTHDR: begin
				n_pkt_left = pl;
				n_run      = data_byte[7];
				if ({24'd0, pl} > cur_pix_left) begin
					emit             = 1'b1;
					push_data.last   = 1'b1;
					push_data.status = tgarle_pkg::ST_OVERRUN;
					n_phase          = PH_IDLE;
				end else begin
					n_pbi   = 2'd0;
					n_pb    = '0;
					n_phase = PH_PKTPIX;
				end
			end
			PH_PKTPIX: begin
				n_pb  = g_pb;
				n_pbi = g_pbi;
				if (g_done) begin
					n_pix_left       = dec;
					n_pkt_left       = cur_pkt_left - rep;
					emit             = 1'b1;
					push_data.px_b0  = cur_pb[7:0];
					push_data.px_b1  = cur_pb[15:8];
					push_data.px_b2  = cur_pb[23:16];
					push_data.px_b3  = data_byte;
					push_data.rep    = rep;
					push_data.last   = (dec == 32'd0);
					if (dec == 32'd0)
						n_phase = PH_IDLE;
					else if (cur_pkt_left == rep)
						n_phase = PH_PKTHDR;
				end
			end
			PH_IDLE: ;
			default: ;
		endcase

		push_data.four   = n_four;
		push_data.width  = n_width;
		push_data.height = n_height;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_TYPE;
			hdr_q      <= 4'd0;
			match_q    <= 2'b11;
			comp_q     <= 1'b0;
			width_q    <= 16'd0;
			height_q   <= 16'd0;
			four_q     <= 1'b0;
			pix_left_q <= 32'd0;
			pkt_left_q <= 8'd0;
			run_q      <= 1'b0;
			pbi_q      <= 2'd0;
			pb_q       <= 24'd0;
		end else if (accept) begin
			phase_q    <= n_phase;
			hdr_q      <= n_hdr;
			match_q    <= n_match;
			comp_q     <= n_comp;
			width_q    <= n_width;
			height_q   <= n_height;
			four_q     <= n_four;
			pix_left_q <= n_pix_left;
			pkt_left_q <= n_pkt_left;
			run_q      <= n_run;
			pbi_q      <= n_pbi;
			pb_q       <= n_pb;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tgarle_queue.sv =====
// Small register queue between parser and output stage.
// Depends on tgarle_pkg for the entry and flag types.
`default_nettype none

module tgarle_queue #(
	parameter int unsigned DEPTH = 4
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire tgarle_pkg::entry_t  push_data,
	input  wire logic                pop,
	output tgarle_pkg::entry_t       pop_data,
	output tgarle_pkg::q_flags_t     flags
);

	localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);

	tgarle_pkg::entry_t mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_push;
	logic               do_pop;

	assign flags.full  = (count_q == CNT_W'(DEPTH));
	assign flags.empty = (count_q == '0);
	assign do_push     = push && !flags.full;
	assign do_pop      = pop && !flags.empty;
	assign pop_data    = mem_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] p);
		return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
	endfunction

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= next_ptr(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= next_ptr(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + CNT_W'(1);
			else if (do_pop && !do_push)
				count_q <= count_q - CNT_W'(1);
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tgarle_back.sv =====
// Output stage: reorders stored BGR(A) bytes to RGBA, fills opaque alpha,
// clears color on error items and holds the result register. Uses tgarle_pkg.
`default_nettype none

module tgarle_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire tgarle_pkg::entry_t   head,
	input  wire tgarle_pkg::q_flags_t q_flags,
	output logic                      pop,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                red,
	output logic [7:0]                green,
	output logic [7:0]                blue,
	output logic [7:0]                alpha,
	output logic [7:0]                repeat_count,
	output logic                      has_alpha,
	output logic [15:0]               image_width,
	output logic [15:0]               image_height,
	output logic                      last_of_image,
	output logic [1:0]                status
);

	logic       valid_q;
	logic       is_pix;
	logic [7:0] r_c, g_c, b_c, a_c;

	assign out_valid = valid_q;
	assign pop       = !q_flags.empty && (!valid_q || !out_stall);
	assign is_pix    = (head.status == tgarle_pkg::ST_PIXEL);

	always_comb begin
		// 24-bit: B,G,R ; 32-bit: B,G,R,A with the final byte last
		b_c = head.px_b0;
		g_c = head.px_b1;
		if (head.four) begin
			r_c = head.px_b2;
			a_c = head.px_b3;
		end else begin
			r_c = head.px_b3;
			a_c = tgarle_pkg::ALPHA_OPAQUE;
		end
		if (!is_pix) begin
			r_c = '0;
			g_c = '0;
			b_c = '0;
			a_c = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (!valid_q || !out_stall)
			valid_q <= !q_flags.empty;
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			red           <= r_c;
			green         <= g_c;
			blue          <= b_c;
			alpha         <= a_c;
			repeat_count  <= is_pix ? head.rep : 8'd0;
			has_alpha     <= head.four;
			image_width   <= head.width;
			image_height  <= head.height;
			last_of_image <= head.last;
			status        <= head.status;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/core/tga_rle_pixel_decoder.sv =====
// TGA true-color decoder top level: parser, result queue and output stage.
// Depends on tgarle_pkg, tgarle_front, tgarle_queue and tgarle_back.
//
// Usage: the file is fed one byte per item on the input channel (in_valid /
// in_stall, data_byte, start_of_file). start_of_file marks type byte 0 of a
// new file and abandons any file in progress. Each decoded pixel or packet
// leaves as one item on the output channel (out_valid / out_stall) with RGBA,
// a repeat count, the header sizes, a last flag and a status code; header and
// overrun faults leave as one error item with last set, after which bytes are
// dropped until the next start_of_file.
// Throughput: one byte per cycle while in_stall is low, since every byte is
// parsed in the cycle it is taken. Path: the byte that completes a result
// pushes it into the queue, and the output register then takes it from there.
// Receiver stall: the output register holds its item; the queue of
// QUEUE_DEPTH entries keeps absorbing results, and in_stall rises only when
// it is full.
// Reset: arst_n clears parser state to wait for a type header and empties the
// queue and output register; the first byte afterwards is type byte 0.
`default_nettype none

module tga_rle_pixel_decoder #(
	parameter int unsigned QUEUE_DEPTH = 4
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_file,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       red,
	output logic [7:0]       green,
	output logic [7:0]       blue,
	output logic [7:0]       alpha,
	output logic [7:0]       repeat_count,
	output logic             has_alpha,
	output logic [15:0]      image_width,
	output logic [15:0]      image_height,
	output logic             last_of_image,
	output logic [1:0]       status
);

	tgarle_pkg::entry_t   push_data;
	tgarle_pkg::entry_t   head;
	tgarle_pkg::q_flags_t q_flags;
	logic                 push;
	logic                 pop;

	tgarle_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.data_byte     (data_byte),
		.start_of_file (start_of_file),
		.q_flags       (q_flags),
		.push          (push),
		.push_data     (push_data)
	);

	tgarle_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pop       (pop),
		.pop_data  (head),
		.flags     (q_flags)
	);

	tgarle_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.head          (head),
		.q_flags       (q_flags),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.red           (red),
		.green         (green),
		.blue          (blue),
		.alpha         (alpha),
		.repeat_count  (repeat_count),
		.has_alpha     (has_alpha),
		.image_width   (image_width),
		.image_height  (image_height),
		.last_of_image (last_of_image),
		.status        (status)
	);

endmodule

`default_nettype wire

// ===== rtl/core/tgarle_checker.sv =====
// Port-level checks for the TGA RLE pixel decoder, bound to the top level.
// Depends on tgarle_pkg for the status codes.
`default_nettype none

module tgarle_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_stall,
	input wire logic [7:0]  red,
	input wire logic [7:0]  green,
	input wire logic [7:0]  blue,
	input wire logic [7:0]  alpha,
	input wire logic [7:0]  repeat_count,
	input wire logic        has_alpha,
	input wire logic [15:0] image_width,
	input wire logic [15:0] image_height,
	input wire logic        last_of_image,
	input wire logic [1:0]  status
);

	// a stalled item stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(red) && $stable(green)
			&& $stable(blue) && $stable(alpha) && $stable(repeat_count)
			&& $stable(status) && $stable(last_of_image))
		else $error("output item changed while stalled");

	// error items end the image and carry no color
	a_err_shape: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != tgarle_pkg::ST_PIXEL |->
			last_of_image && repeat_count == 8'd0 && red == 8'd0 && green == 8'd0
			&& blue == 8'd0 && alpha == 8'd0)
		else $error("malformed error item");

	a_pix_rep: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tgarle_pkg::ST_PIXEL |->
			repeat_count != 8'd0 && repeat_count <= 8'd128)
		else $error("pixel repeat count out of range");

	// 24-bit pixels are opaque
	a_opaque: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tgarle_pkg::ST_PIXEL && !has_alpha |-> alpha == 8'hFF)
		else $error("24-bit pixel without opaque alpha");

	// a bad type header is seen before any size is stored
	a_type_sizes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == tgarle_pkg::ST_BAD_TYPE |->
			image_width == 16'd0 && image_height == 16'd0 && !has_alpha)
		else $error("type error with stored sizes");

endmodule

bind tga_rle_pixel_decoder tgarle_checker u_tgarle_checker (.*);

`default_nettype wire

// ===== tb/tga_decode_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the TGA RLE pixel decoder. It predicts results from the accepted
// bytes and compares every item that leaves the output channel. Depends on tgarle_pkg.
module tga_decode_checker (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	input  wire logic        in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        start_of_file,
	input  wire logic        out_valid,
	input  wire logic        out_stall,
	input  wire logic [7:0]  red,
	input  wire logic [7:0]  green,
	input  wire logic [7:0]  blue,
	input  wire logic [7:0]  alpha,
	input  wire logic [7:0]  repeat_count,
	input  wire logic        has_alpha,
	input  wire logic [15:0] image_width,
	input  wire logic [15:0] image_height,
	input  wire logic        last_of_image,
	input  wire logic [1:0]  status,
	output int               mismatches,
	output int               pending
);

	typedef enum logic [2:0] {
		PH_TYPE,
		PH_IMG,
		PH_RAW,
		PH_PKT_HDR,
		PH_PKT_PIX,
		PH_DONE
	} parse_phase_t;

	typedef struct packed {
		logic [7:0]          r;
		logic [7:0]          g;
		logic [7:0]          b;
		logic [7:0]          a;
		logic [7:0]          rep;
		logic                four;
		logic [15:0]         w;
		logic [15:0]         h;
		logic                last;
		tgarle_pkg::status_t st;
	} pixel_result_t;

	pixel_result_t expected_px[$];

	parse_phase_t phase;
	logic [4:0]   hdr_idx;
	logic [1:0]   type_match;	// bit 0 uncompressed, bit 1 RLE
	logic         rle_mode;
	logic [15:0]  width_st;
	logic [15:0]  height_st;
	logic [7:0]   depth_st;
	logic         four_bpp;
	logic [31:0]  px_left;
	logic [7:0]   pkt_left;
	logic         pkt_run;
	logic [1:0]   pb_idx;
	logic [23:0]  pb;

	task automatic restart_parser();
		phase = PH_TYPE;
		hdr_idx = '0;
		type_match = 2'b11;
		rle_mode = 1'b0;
		width_st = '0;
		height_st = '0;
		depth_st = '0;
		four_bpp = 1'b0;
		px_left = '0;
		pkt_left = '0;
		pkt_run = 1'b0;
		pb_idx = '0;
		pb = '0;
	endtask

	task automatic queue_result(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
			input logic [7:0] a, input logic [7:0] rep, input logic last,
			input tgarle_pkg::status_t st);
		pixel_result_t e;
		e.r = r;
		e.g = g;
		e.b = b;
		e.a = a;
		e.rep = rep;
		e.four = four_bpp;
		e.w = width_st;
		e.h = height_st;
		e.last = last;
		e.st = st;
		expected_px.push_back(e);
	endtask

	// Faults end the file: everything up to the next start_of_file is dropped.
	task automatic flag_error(input tgarle_pkg::status_t st);
		queue_result(8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 1'b1, st);
		phase = PH_DONE;
	endtask

	// Stored order is B,G,R(,A); done rises on the closing byte of a pixel.
	task automatic take_pixel_byte(input logic [7:0] d, output logic done, output logic [7:0] r,
			output logic [7:0] g, output logic [7:0] b, output logic [7:0] a);
		logic [1:0] last_idx;
		last_idx = four_bpp ? 2'd3 : 2'd2;
		r = '0;
		g = '0;
		b = '0;
		a = '0;
		done = 1'b0;
		if (pb_idx < last_idx) begin
			pb = pb | ({16'd0, d} << (8 * pb_idx));
			pb_idx = pb_idx + 2'd1;
		end else begin
			if (four_bpp) begin
				r = pb[23:16];
				a = d;
			end else begin
				r = d;
				a = tgarle_pkg::ALPHA_OPAQUE;
			end
			g = pb[15:8];
			b = pb[7:0];
			pb_idx = '0;
			pb = '0;
			done = 1'b1;
		end
	endtask

	task automatic decode_byte(input logic [7:0] d, input logic sof);
		logic [3:0] idx;
		logic       done;
		logic       last;
		logic [7:0] r, g, b, a, rep;
		if (sof)
			restart_parser();
		case (phase)
			PH_TYPE: begin
				idx = (hdr_idx < tgarle_pkg::TYPE_HDR_LEN) ? hdr_idx[3:0]
					: 4'(tgarle_pkg::TYPE_HDR_LEN - 1);
				if (d != ((idx == tgarle_pkg::TYPE_CODE_POS) ? tgarle_pkg::TYPE_CODE_UNC : 8'd0))
					type_match[0] = 1'b0;
				if (d != ((idx == tgarle_pkg::TYPE_CODE_POS) ? tgarle_pkg::TYPE_CODE_RLE : 8'd0))
					type_match[1] = 1'b0;
				if (idx < tgarle_pkg::TYPE_HDR_LEN - 1) begin
					hdr_idx = {1'b0, idx} + 5'd1;
				end else begin
					hdr_idx = '0;
					if (type_match[0]) begin
						rle_mode = 1'b0;
						phase = PH_IMG;
					end else if (type_match[1]) begin
						rle_mode = 1'b1;
						phase = PH_IMG;
					end else begin
						flag_error(tgarle_pkg::ST_BAD_TYPE);
					end
				end
			end
			PH_IMG: begin
				case (hdr_idx)
					5'd0: width_st[7:0] = d;
					5'd1: width_st[15:8] = d;
					5'd2: height_st[7:0] = d;
					5'd3: height_st[15:8] = d;
					5'd4: begin
						four_bpp = (d == tgarle_pkg::DEPTH_32);
						depth_st = d;
					end
					default: ;
				endcase
				if (hdr_idx < tgarle_pkg::IMG_HDR_LEN - 1) begin
					hdr_idx = hdr_idx + 5'd1;
				end else begin
					hdr_idx = '0;
					if (width_st == 0 || height_st == 0 ||
							(depth_st != tgarle_pkg::DEPTH_24 &&
							depth_st != tgarle_pkg::DEPTH_32)) begin
						flag_error(tgarle_pkg::ST_BAD_SIZE);
					end else begin
						px_left = {16'd0, width_st} * {16'd0, height_st};
						phase = rle_mode ? PH_PKT_HDR : PH_RAW;
					end
				end
			end
			PH_RAW: begin
				take_pixel_byte(d, done, r, g, b, a);
				if (done) begin
					px_left = px_left - 32'd1;
					last = (px_left == 0);
					if (last)
						phase = PH_DONE;
					queue_result(r, g, b, a, 8'd1, last, tgarle_pkg::ST_PIXEL);
				end
			end
			PH_PKT_HDR: begin
				if (d < 8'd128) begin
					pkt_left = d + 8'd1;
					pkt_run = 1'b0;
				end else begin
					pkt_left = d - tgarle_pkg::RUN_BIAS;
					pkt_run = 1'b1;
				end
				// an oversized packet is refused before any of its pixels
				if ({24'd0, pkt_left} > px_left) begin
					flag_error(tgarle_pkg::ST_OVERRUN);
				end else begin
					pb_idx = '0;
					pb = '0;
					phase = PH_PKT_PIX;
				end
			end
			PH_PKT_PIX: begin
				take_pixel_byte(d, done, r, g, b, a);
				if (done) begin
					rep = pkt_run ? pkt_left : 8'd1;
					px_left = px_left - {24'd0, rep};
					pkt_left = pkt_left - rep;
					last = (px_left == 0);
					if (last)
						phase = PH_DONE;
					else if (pkt_left == 0)
						phase = PH_PKT_HDR;
					queue_result(r, g, b, a, rep, last, tgarle_pkg::ST_PIXEL);
				end
			end
			default: ;
		endcase
	endtask

	task automatic check_field(input string name, input int unsigned want, input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : sample
		pixel_result_t e;
		if (!arst_n) begin
			restart_parser();
		end else begin
			if (out_valid && !out_stall) begin
				if (expected_px.size() == 0) begin
					$error("result item with no expected result waiting");
					mismatches++;
				end else begin
					e = expected_px.pop_front();
					check_field("red", 32'(e.r), 32'(red));
					check_field("green", 32'(e.g), 32'(green));
					check_field("blue", 32'(e.b), 32'(blue));
					check_field("alpha", 32'(e.a), 32'(alpha));
					check_field("repeat_count", 32'(e.rep), 32'(repeat_count));
					check_field("has_alpha", 32'(e.four), 32'(has_alpha));
					check_field("image_width", 32'(e.w), 32'(image_width));
					check_field("image_height", 32'(e.h), 32'(image_height));
					check_field("last_of_image", 32'(e.last), 32'(last_of_image));
					check_field("status", 32'(e.st), 32'(status));
				end
			end
			if (in_valid && !in_stall)
				decode_byte(data_byte, start_of_file);
		end
		pending = expected_px.size();
	end

endmodule

// ===== tb/tga_rle_pixel_decoder_tb.sv =====
`timescale 1ns / 100ps
// Top of the TGA RLE pixel decoder testbench: clock, reset, byte stimulus, receiver
// stalls and verdict. Depends on tgarle_pkg, tga_rle_pixel_decoder and tga_decode_checker.
module tga_rle_pixel_decoder_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int HOLD_CYCLES = 300;
	localparam int ITEM_TARGET = 650;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic [7:0]  data_byte;
	logic        start_of_file;
	logic        out_valid;
	logic        out_stall;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;
	logic [7:0]  repeat_count;
	logic        has_alpha;
	logic [15:0] image_width;
	logic [15:0] image_height;
	logic        last_of_image;
	logic [1:0]  status;
	int          mismatches;
	int          pending;

	logic        quiet;		// no idling on either side
	logic        hold_req;
	logic        hold_taken;
	int          hold_left;
	int          cycles;
	int          sent_bytes;
	logic [7:0]  file_buf[$];

	tga_rle_pixel_decoder u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.start_of_file(start_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.repeat_count(repeat_count),
		.has_alpha(has_alpha),
		.image_width(image_width),
		.image_height(image_height),
		.last_of_image(last_of_image),
		.status(status)
	);

	tga_decode_checker u_check (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.data_byte(data_byte),
		.start_of_file(start_of_file),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.red(red),
		.green(green),
		.blue(blue),
		.alpha(alpha),
		.repeat_count(repeat_count),
		.has_alpha(has_alpha),
		.image_width(image_width),
		.image_height(image_height),
		.last_of_image(last_of_image),
		.status(status),
		.mismatches(mismatches),
		.pending(pending)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Receiver: random stalls, one long hold-off on request, none while quiet.
	initial begin
		out_stall = 1'b0;
		hold_taken = 1'b0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_taken) begin
				hold_taken = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else if (quiet) begin
				out_stall <= 1'b0;
			end else begin
				out_stall <= ($urandom_range(0, 99) < 10);
			end
		end
	end

	task automatic add_header(input logic rle, input logic [15:0] w, input logic [15:0] h,
			input logic [7:0] depth);
		for (int i = 0; i < tgarle_pkg::TYPE_HDR_LEN; i++)
			file_buf.push_back((i == tgarle_pkg::TYPE_CODE_POS)
				? (rle ? tgarle_pkg::TYPE_CODE_RLE : tgarle_pkg::TYPE_CODE_UNC) : 8'd0);
		file_buf.push_back(w[7:0]);
		file_buf.push_back(w[15:8]);
		file_buf.push_back(h[7:0]);
		file_buf.push_back(h[15:8]);
		file_buf.push_back(depth);
		file_buf.push_back(8'($urandom_range(0, 255)));
	endtask

	task automatic add_pixel(input logic four, input logic [31:0] px);
		file_buf.push_back(px[7:0]);
		file_buf.push_back(px[15:8]);
		file_buf.push_back(px[23:16]);
		if (four)
			file_buf.push_back(px[31:24]);
	endtask

	// Called at a falling edge; returns at the falling edge after acceptance.
	task automatic send_byte(input logic [7:0] d, input logic sof);
		if (!quiet && $urandom_range(0, 99) < 10) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 3)) @(negedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= d;
		start_of_file <= sof;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_file(input logic sof);
		sent_bytes += file_buf.size();
		foreach (file_buf[i])
			send_byte(file_buf[i], sof && (i == 0));
		file_buf.delete();
	endtask

	initial begin : stimulus
		int          file_no;
		int          kind;
		int          rem;
		int          n;
		int          cut;
		logic        rle;
		logic        four;
		logic [15:0] w;
		logic [15:0] h;
		logic [7:0]  depth;

		arst_n = 1'b0;
		in_valid = 1'b0;
		data_byte = 8'd0;
		start_of_file = 1'b0;
		// directed files go through with no idling on either side
		quiet = 1'b1;
		hold_req = 1'b0;
		sent_bytes = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// first file without start_of_file, raw 24-bit, extreme colors, trailing junk
		add_header(1'b0, 16'd2, 16'd1, tgarle_pkg::DEPTH_24);
		add_pixel(1'b0, 32'h0000_0000);
		add_pixel(1'b0, 32'hFFFF_FFFF);
		file_buf.push_back(8'hA5);
		send_file(1'b0);

		// type header of all ones
		add_header(1'b0, 16'd1, 16'd1, tgarle_pkg::DEPTH_24);
		foreach (file_buf[i])
			file_buf[i] = 8'hFF;
		send_file(1'b1);

		// zero width, zero height, unsupported depth
		add_header(1'b1, 16'd0, 16'd5, tgarle_pkg::DEPTH_24);
		send_file(1'b1);
		add_header(1'b0, 16'd3, 16'd0, tgarle_pkg::DEPTH_32);
		send_file(1'b1);
		add_header(1'b0, 16'd1, 16'd1, 8'd16);
		send_file(1'b1);

		// RLE 32-bit 2x2: a run of two, then a raw packet of two
		add_header(1'b1, 16'd2, 16'd2, tgarle_pkg::DEPTH_32);
		file_buf.push_back(8'h81);
		add_pixel(1'b1, 32'h1122_3344);
		file_buf.push_back(8'h01);
		add_pixel(1'b1, 32'h0000_0000);
		add_pixel(1'b1, 32'hFFFF_FFFF);
		file_buf.push_back(8'h00);
		send_file(1'b1);

		// overruns: a run of 128 and a raw packet of 3 against smaller images
		add_header(1'b1, 16'd1, 16'd1, tgarle_pkg::DEPTH_24);
		file_buf.push_back(8'hFF);
		add_pixel(1'b0, 32'h0012_3456);
		send_file(1'b1);
		add_header(1'b1, 16'd2, 16'd1, tgarle_pkg::DEPTH_24);
		file_buf.push_back(8'h02);
		send_file(1'b1);

		// longest run fills the image exactly
		add_header(1'b1, 16'd128, 16'd1, tgarle_pkg::DEPTH_24);
		file_buf.push_back(8'hFF);
		add_pixel(1'b0, 32'h00AB_CDEF);
		send_file(1'b1);

		// largest sizes, abandoned after a run and part of a raw packet
		add_header(1'b1, 16'hFFFF, 16'hFFFF, tgarle_pkg::DEPTH_32);
		file_buf.push_back(8'h80);
		add_pixel(1'b1, 32'h8040_2010);
		file_buf.push_back(8'h7F);
		add_pixel(1'b1, 32'h0102_0304);
		send_file(1'b1);

		// raw 32-bit file cut off mid-pixel
		add_header(1'b0, 16'd1, 16'd1, tgarle_pkg::DEPTH_32);
		file_buf.push_back(8'h55);
		file_buf.push_back(8'hAA);
		send_file(1'b1);

		quiet <= 1'b0;
		file_no = 0;
		while (sent_bytes < ITEM_TARGET) begin
			file_no++;
			if (file_no == 2)
				hold_req <= 1'b1;
			if (file_no == 4) begin
				// let the block drain completely before going on
				in_valid <= 1'b0;
				@(negedge clk);
				while (pending != 0)
					@(negedge clk);
			end

			kind = $urandom_range(0, 99);
			rle = 1'($urandom_range(0, 1));
			four = 1'($urandom_range(0, 1));
			w = 16'($urandom_range(1, 6));
			h = 16'($urandom_range(1, 4));
			if (kind < 8) begin
				rle = 1'b1;
				w = 16'd256;
				h = 16'd1;
			end
			depth = four ? tgarle_pkg::DEPTH_32 : tgarle_pkg::DEPTH_24;

			if (kind >= 70 && kind < 80) begin
				add_header(rle, w, h, depth);
				file_buf[$urandom_range(0, tgarle_pkg::TYPE_HDR_LEN - 1)] =
					8'($urandom_range(0, 255));
				add_pixel(four, $urandom);
			end else if (kind >= 80 && kind < 90) begin
				case ($urandom_range(0, 2))
					0: w = 16'd0;
					1: h = 16'd0;
					default: depth = 8'($urandom_range(0, 255));
				endcase
				add_header(rle, w, h, depth);
				add_pixel(four, $urandom);
			end else begin
				if (kind >= 90)
					rle = 1'b1;
				add_header(rle, w, h, depth);
				rem = int'(w) * int'(h);
				if (!rle) begin
					repeat (rem) add_pixel(four, $urandom);
				end else begin
					while (rem > 0) begin
						if (kind >= 90 && rem < 128 && $urandom_range(0, 2) == 0) begin
							n = rem + $urandom_range(1, 3);
							if (n > 128)
								n = 128;
							file_buf.push_back($urandom_range(0, 1) ? 8'(127 + n) : 8'(n - 1));
							add_pixel(four, $urandom);
							rem = 0;
						end else if ($urandom_range(0, 1)) begin
							n = $urandom_range(1, (rem < 128) ? rem : 128);
							file_buf.push_back(8'(127 + n));
							add_pixel(four, $urandom);
							rem -= n;
						end else begin
							n = $urandom_range(1, (rem < 4) ? rem : 4);
							file_buf.push_back(8'(n - 1));
							repeat (n) add_pixel(four, $urandom);
							rem -= n;
						end
					end
				end
				if ($urandom_range(0, 9) == 0) begin
					cut = $urandom_range(1, file_buf.size());
					while (file_buf.size() > cut)
						void'(file_buf.pop_back());
				end else if ($urandom_range(0, 9) == 0) begin
					repeat ($urandom_range(1, 4)) file_buf.push_back(8'($urandom_range(0, 255)));
				end
			end
			send_file(1'b1);
		end

		in_valid <= 1'b0;
		@(negedge clk);
		while (pending != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
